/* rtl/gcmd_pkg.sv */
// ----------------------------------------------------------------------------
// gcmd_pkg
// Shared types and constants for the all-pairs graph center block.
// ----------------------------------------------------------------------------
package gcmd_pkg;

    localparam int MAX_VERTICES_DEF = 16;
    localparam int WEIGHT_BITS_DEF  = 16;
    localparam int DIST_BITS_DEF    = 24;
    localparam int VID_BITS         = 7;
    localparam int IN_W_BITS        = 16;
    localparam int SUM_BITS         = 30;
    localparam int OUT_BITS         = 24;
    localparam logic [VID_BITS-1:0] CNT_RESET = 7'd16;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_SRC_INIT,
        ST_SELECT,
        ST_PICK,
        ST_RELAX,
        ST_REDUCE,
        ST_STORE,
        ST_FLAGS,
        ST_EMIT,
        ST_CLEAR
    } t_state;

endpackage

/* rtl/graph_center_median_by_dijkstra_core.sv */
// ----------------------------------------------------------------------------
// graph_center_median_by_dijkstra_core
// All-pairs Dijkstra over an edge-loaded adjacency memory with graph center,
// median and anticenter reporting.
// ----------------------------------------------------------------------------
// Edges are taken one word at a time and written twice into the adjacency
// memory (once for each direction); the reverse write holds off the next word,
// so the block drops stall on alternating cycles during loading. After the word
// marked last, Dijkstra runs from every vertex with one shared compare/add
// unit: each round scans the n distances for the minimum, picks it, and then
// relaxes the n neighbors, one memory read per cycle; n result words follow.
// After the last result the memory is swept clear, one entry per cycle over
// all 2^(2*ceil(log2(MAX_VERTICES))) entries, before the next edge is taken;
// the same sweep runs after reset.
// ----------------------------------------------------------------------------
module graph_center_median_by_dijkstra_core #(
    parameter int MAX_VERTICES = gcmd_pkg::MAX_VERTICES_DEF,
    parameter int WEIGHT_BITS  = gcmd_pkg::WEIGHT_BITS_DEF,
    parameter int DIST_BITS    = gcmd_pkg::DIST_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [6:0]  i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [6:0]  i_from_vertex,
    input  logic [6:0]  i_to_vertex,
    input  logic [15:0] i_edge_weight,
    input  logic        i_last_edge,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [6:0]  o_vertex_id,
    output logic [29:0] o_distance_sum,
    output logic [23:0] o_eccentricity,
    output logic [23:0] o_nearest_distance,
    output logic        o_is_center,
    output logic        o_is_median,
    output logic        o_is_anticenter,
    output logic        o_last_vertex
);
    localparam int VB = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int AB = 2 * VB;
    localparam int CB = VB + 1;
    localparam logic [DIST_BITS-1:0] INF = {DIST_BITS{1'b1}};
    localparam int SB = gcmd_pkg::SUM_BITS;
    localparam int OB = gcmd_pkg::OUT_BITS;
    localparam int XB = (SB > DIST_BITS ? SB : DIST_BITS) + 1;

    gcmd_pkg::t_state r_state, n_state;

    logic [6:0]             r_cnt;
    logic [CB-1:0]          r_n;
    logic [VB-1:0]          r_src, r_i, r_u, r_best;
    logic                   r_bvalid;
    logic [CB-1:0]          r_it;
    logic                   r_phase;
    logic                   r_rd_ok;
    logic [VB-1:0]          r_rd_j;
    logic [AB:0]            r_clr;
    logic [DIST_BITS-1:0]   r_dist [0:MAX_VERTICES-1];
    logic [MAX_VERTICES-1:0] r_set;
    logic [SB-1:0]          r_sum;
    logic [DIST_BITS-1:0]   r_mx, r_mn;
    logic [SB-1:0]          r_rsum [0:MAX_VERTICES-1];
    logic [OB-1:0]          r_rmax [0:MAX_VERTICES-1];
    logic [OB-1:0]          r_rmin [0:MAX_VERTICES-1];
    logic [SB-1:0]          r_min_sum;
    logic [OB-1:0]          r_min_ecc, r_max_near;
    logic [VB-1:0]          r_e;

    // Input staging of the current edge.
    logic [VB-1:0]          r_ef, r_et;
    logic [WEIGHT_BITS-1:0] r_ew;
    logic                   r_eok, r_elast;

    logic                   mem_we;
    logic [AB-1:0]          mem_wa, mem_ra;
    logic [WEIGHT_BITS-1:0] mem_wd, mem_rd;

    gcmd_adj_mem #(.ABITS(AB), .WBITS(WEIGHT_BITS)) u_mem (
        .i_clk(i_clk), .i_we(mem_we), .i_waddr(mem_wa), .i_wdata(mem_wd),
        .i_raddr(mem_ra), .o_rdata(mem_rd)
    );

    wire in_acc  = i_valid && !o_stall;
    wire f_ok    = (i_from_vertex != 7'd0) && ({25'd0, i_from_vertex} <= MAX_VERTICES);
    wire t_ok    = (i_to_vertex != 7'd0) && ({25'd0, i_to_vertex} <= MAX_VERTICES);
    wire last_n  = ({1'b0, r_i} == r_n - CB'(1));

    // Endpoints of the incoming word as zero-based indexes.
    wire [VB-1:0] in_f = VB'(i_from_vertex - 7'd1);
    wire [VB-1:0] in_t = VB'(i_to_vertex - 7'd1);

    // Shared unit: saturating distance add.
    logic [DIST_BITS:0] cand;
    assign cand = {1'b0, r_dist[r_u]} + (DIST_BITS+1)'(mem_rd);
    logic [DIST_BITS-1:0] cand_s;
    assign cand_s = cand[DIST_BITS] ? INF : cand[DIST_BITS-1:0];

    logic [XB-1:0] sum_x;
    assign sum_x = XB'(r_sum) + XB'(r_dist[r_i]);

    function automatic logic [OB-1:0] to_out(input logic [DIST_BITS-1:0] v);
        logic [XB-1:0] vx;
        vx = XB'(v);
        if (v == INF || vx >= XB'({OB{1'b1}})) to_out = {OB{1'b1}};
        else to_out = OB'(v);
    endfunction

    always_comb begin
        n_state = r_state;
        o_stall = 1'b1;
        mem_we  = 1'b0;
        mem_wa  = {r_ef, r_et};
        mem_wd  = r_ew;
        mem_ra  = {r_u, r_i};
        case (r_state)
            gcmd_pkg::ST_LOAD: begin
                o_stall = r_phase;
                if (r_phase) begin
                    // Phase after the word is taken: the reverse direction.
                    mem_we = r_eok;
                    mem_wa = {r_et, r_ef};
                    if (r_elast) n_state = gcmd_pkg::ST_SRC_INIT;
                end else begin
                    // The forward direction is written as the word is taken.
                    mem_we = in_acc && f_ok && t_ok;
                    mem_wa = {in_f, in_t};
                    mem_wd = WEIGHT_BITS'(i_edge_weight);
                end
            end
            gcmd_pkg::ST_SRC_INIT: n_state = gcmd_pkg::ST_SELECT;
            gcmd_pkg::ST_SELECT: if (last_n) n_state = gcmd_pkg::ST_PICK;
            gcmd_pkg::ST_PICK: begin
                if (r_it == r_n - CB'(1) || !r_bvalid) n_state = gcmd_pkg::ST_REDUCE;
                else if (r_dist[r_best] == INF) n_state = gcmd_pkg::ST_SELECT;
                else n_state = gcmd_pkg::ST_RELAX;
            end
            gcmd_pkg::ST_RELAX: if (r_rd_ok && r_rd_j == VB'(r_n - CB'(1)))
                n_state = gcmd_pkg::ST_SELECT;
            gcmd_pkg::ST_REDUCE: if (last_n) n_state = gcmd_pkg::ST_STORE;
            gcmd_pkg::ST_STORE: n_state = ({1'b0, r_src} == r_n - CB'(1)) ?
                gcmd_pkg::ST_FLAGS : gcmd_pkg::ST_SRC_INIT;
            gcmd_pkg::ST_FLAGS: if (last_n) n_state = gcmd_pkg::ST_EMIT;
            gcmd_pkg::ST_EMIT: if (o_valid && !i_stall && o_last_vertex)
                n_state = gcmd_pkg::ST_CLEAR;
            gcmd_pkg::ST_CLEAR: begin
                mem_we = 1'b1;
                mem_wa = r_clr[AB-1:0];
                mem_wd = '0;
                if (r_clr[AB]) n_state = gcmd_pkg::ST_LOAD;
            end
            default: n_state = gcmd_pkg::ST_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= gcmd_pkg::ST_CLEAR;
            r_cnt   <= gcmd_pkg::CNT_RESET;
            r_phase <= 1'b0;
            r_clr   <= '0;
            o_valid <= 1'b0;
            r_rd_ok <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) r_cnt <= i_cfg_data;
            case (r_state)
                gcmd_pkg::ST_LOAD: begin
                    r_clr <= '0;
                    if (r_phase) begin
                        r_phase <= 1'b0;
                        if (r_elast) begin
                            r_src <= '0;
                            if (r_cnt == 7'd0) r_n <= CB'(1);
                            else if ({25'd0, r_cnt} > MAX_VERTICES) r_n <= CB'(MAX_VERTICES);
                            else r_n <= CB'(r_cnt);
                        end
                    end else if (in_acc) begin
                        r_phase <= 1'b1;
                        r_ef    <= in_f;
                        r_et    <= in_t;
                        r_ew    <= WEIGHT_BITS'(i_edge_weight);
                        r_eok   <= f_ok && t_ok;
                        r_elast <= i_last_edge;
                    end
                end
                gcmd_pkg::ST_SRC_INIT: begin
                    for (int k = 0; k < MAX_VERTICES; k++) begin
                        r_dist[k] <= (VB'(k) == r_src) ? '0 : INF;
                    end
                    r_set <= '0; r_it <= '0; r_i <= '0; r_bvalid <= 1'b0;
                end
                gcmd_pkg::ST_SELECT: begin
                    if (!r_set[r_i] && (!r_bvalid || r_dist[r_i] <= r_dist[r_best])) begin
                        r_best <= r_i; r_bvalid <= 1'b1;
                    end
                    r_i <= last_n ? '0 : r_i + VB'(1);
                end
                gcmd_pkg::ST_PICK: begin
                    r_u <= r_best;
                    if (r_bvalid) r_set[r_best] <= 1'b1;
                    r_it <= r_it + CB'(1);
                    r_bvalid <= 1'b0;
                    r_i <= '0; r_rd_ok <= 1'b0;
                    r_sum <= '0; r_mx <= '0; r_mn <= INF;
                end
                gcmd_pkg::ST_RELAX: begin
                    r_rd_j <= r_i;
                    if (r_rd_ok && !r_set[r_rd_j] && mem_rd != '0 && cand_s < r_dist[r_rd_j])
                        r_dist[r_rd_j] <= cand_s;
                    if (r_rd_ok && r_rd_j == VB'(r_n - CB'(1))) begin
                        r_i <= '0; r_rd_ok <= 1'b0;
                    end else begin
                        r_rd_ok <= 1'b1;
                        if (!last_n) r_i <= r_i + VB'(1);
                    end
                end
                gcmd_pkg::ST_REDUCE: begin
                    r_sum <= (sum_x > XB'({SB{1'b1}})) ? {SB{1'b1}} : SB'(sum_x);
                    if (r_dist[r_i] > r_mx) r_mx <= r_dist[r_i];
                    if (r_dist[r_i] != '0 && r_dist[r_i] < r_mn) r_mn <= r_dist[r_i];
                    r_i <= last_n ? '0 : r_i + VB'(1);
                end
                gcmd_pkg::ST_STORE: begin
                    r_rsum[r_src] <= r_sum;
                    r_rmax[r_src] <= to_out(r_mx);
                    r_rmin[r_src] <= to_out((r_mn < r_mx) ? r_mn : r_mx);
                    r_src <= r_src + VB'(1);
                    r_i <= '0;
                end
                gcmd_pkg::ST_FLAGS: begin
                    if (r_i == '0 || r_rsum[r_i] < r_min_sum) r_min_sum <= r_rsum[r_i];
                    if (r_i == '0 || r_rmax[r_i] < r_min_ecc) r_min_ecc <= r_rmax[r_i];
                    if (r_i == '0 || r_rmin[r_i] > r_max_near) r_max_near <= r_rmin[r_i];
                    r_i <= last_n ? '0 : r_i + VB'(1);
                    r_e <= '0;
                end
                gcmd_pkg::ST_EMIT: begin
                    if (!o_valid || !i_stall) begin
                        if (o_valid && o_last_vertex) begin
                            o_valid <= 1'b0;
                        end else begin
                            o_valid            <= 1'b1;
                            o_vertex_id        <= 7'(r_e) + 7'd1;
                            o_distance_sum     <= r_rsum[r_e];
                            o_eccentricity     <= r_rmax[r_e];
                            o_nearest_distance <= r_rmin[r_e];
                            o_is_center        <= r_rmax[r_e] == r_min_ecc;
                            o_is_median        <= r_rsum[r_e] == r_min_sum;
                            o_is_anticenter    <= r_rmin[r_e] == r_max_near;
                            o_last_vertex      <= {1'b0, r_e} == r_n - CB'(1);
                            r_e                <= r_e + VB'(1);
                        end
                    end
                end
                gcmd_pkg::ST_CLEAR: begin
                    o_valid <= 1'b0;
                    r_clr <= r_clr + (AB+1)'(1);
                end
                default: ;
            endcase
        end
    end

    // Input is stalled outside loading, no result word appears during loading, and each source starts at distance zero.
    a_stall_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != gcmd_pkg::ST_LOAD) |-> o_stall)
        else $error("input taken while computing");
    a_no_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == gcmd_pkg::ST_LOAD) |-> !o_valid)
        else $error("result word during loading");
    a_src_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == gcmd_pkg::ST_SELECT && $past(r_state) == gcmd_pkg::ST_SRC_INIT)
        |-> r_dist[r_src] == '0)
        else $error("source distance not zero");
endmodule

/* rtl/gcmd_adj_mem.sv */
// ----------------------------------------------------------------------------
// gcmd_adj_mem
// Adjacency weight memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
module gcmd_adj_mem #(
    parameter int ABITS = 8,
    parameter int WBITS = 16
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [ABITS-1:0] i_waddr,
    input  logic [WBITS-1:0] i_wdata,
    input  logic [ABITS-1:0] i_raddr,
    output logic [WBITS-1:0] o_rdata
);
    logic [WBITS-1:0] r_mem [0:(1<<ABITS)-1];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
